[rtl/core/fwmc_pkg.sv]
package fwmc_pkg;

	// Sizes of the word and pattern stores and of the word counter.
	localparam int MAX_LETTERS = 16;
	localparam int MAX_WORDS   = 32;

	localparam int CHAR_W = 8;
	localparam int IDX_W  = $clog2(MAX_LETTERS);
	localparam int LEN_W  = $clog2(MAX_LETTERS + 1);
	localparam int NUM_W  = $clog2(MAX_WORDS + 1);
	localparam int OCC_W  = LEN_W;

	// Character codes that the block recognises.
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'd90;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'd122;
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;        // input channel ready
		logic prep;        // start closing the current word
		logic step;        // one compare of the substring search
		logic emit_word;   // load a word report into the output register
		logic emit_total;  // load the total report into the output register
		logic run_last;    // the word report is the last result of its transfer
	} fwmc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic accept;       // an input transfer happens this cycle
		logic close_req;    // the input character closes a word
		logic in_end;       // the input character ends the line
		logic word_full;    // the word limit has been reached
		logic search_done;  // no start position left to try
		logic out_free;     // the output register can take a result
	} fwmc_status_t;

endpackage

[rtl/core/fwmc_if.sv]
interface fwmc_char_if import fwmc_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              line_end;

	modport source (output valid, output char_code, output line_end, input ready);
	modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

interface fwmc_rpt_if import fwmc_pkg::*; ;
	logic             valid;
	logic             ready;
	logic             is_total;
	logic [NUM_W-1:0] word_number;
	logic             word_equal;
	logic [OCC_W-1:0] occurrences;
	logic [NUM_W-1:0] equal_total;
	logic             run_last;

	modport source (output valid, output is_total, output word_number, output word_equal,
		output occurrences, output equal_total, output run_last, input ready);
	modport sink   (input valid, input is_total, input word_number, input word_equal,
		input occurrences, input equal_total, input run_last, output ready);
endinterface

[rtl/core/fwmc_ctrl.sv]
module fwmc_ctrl import fwmc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  fwmc_status_t status,
	output fwmc_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PREP   = 3'd1;
	localparam logic [2:0] ST_SEARCH = 3'd2;
	localparam logic [2:0] ST_WORD   = 3'd3;
	localparam logic [2:0] ST_TOTAL  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       end_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.take = 1'b1;
				if (status.accept && status.close_req) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				if (!status.word_full) begin
					state_d = ST_SEARCH;
				end else if (end_q) begin
					state_d = ST_TOTAL;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SEARCH: begin
				if (status.search_done) begin
					state_d = ST_WORD;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_WORD: begin
				cmd.run_last = !end_q;
				if (status.out_free) begin
					cmd.emit_word = 1'b1;
					state_d       = end_q ? ST_TOTAL : ST_IDLE;
				end
			end
			ST_TOTAL: begin
				if (status.out_free) begin
					cmd.emit_total = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			end_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (status.accept) begin
				end_q <= status.in_end;
			end
		end
	end

endmodule

[rtl/core/fwmc_dp.sv]
module fwmc_dp import fwmc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	fwmc_char_if.sink     chars,
	fwmc_rpt_if.source    reports,
	input  fwmc_cmd_t     cmd,
	output fwmc_status_t  status
);

	logic [CHAR_W-1:0] word_q [MAX_LETTERS];
	logic [CHAR_W-1:0] pat_q  [MAX_LETTERS];
	logic [LEN_W-1:0]  wl_q;
	logic [LEN_W-1:0]  pl_q;
	logic [NUM_W-1:0]  wi_q;
	logic [NUM_W-1:0]  eqc_q;
	logic [LEN_W-1:0]  j_q;
	logic [LEN_W-1:0]  k_q;
	logic [OCC_W-1:0]  occ_q;
	logic              out_valid_q;
	logic              out_total_q;
	logic [NUM_W-1:0]  out_num_q;
	logic              out_eq_q;
	logic [OCC_W-1:0]  out_occ_q;
	logic [NUM_W-1:0]  out_etot_q;
	logic              out_last_q;

	logic              accept;
	logic              is_letter;
	logic              store_letter;
	logic [LEN_W-1:0]  sum_jk;
	logic [LEN_W:0]    span_end;
	logic              chars_match;
	logic              last_k;
	logic              word_eq;

	assign accept = chars.valid && cmd.take;
	assign chars.ready = cmd.take;

	assign is_letter = ((chars.char_code >= CHAR_UPPER_A) && (chars.char_code <= CHAR_UPPER_Z))
		|| ((chars.char_code >= CHAR_LOWER_A) && (chars.char_code <= CHAR_LOWER_Z));
	assign store_letter = accept && is_letter && (wl_q < LEN_W'(MAX_LETTERS));

	// One compare per cycle: word letter j+k against pattern letter k.
	assign sum_jk      = j_q + k_q;
	assign span_end    = {1'b0, j_q} + {1'b0, pl_q};
	assign chars_match = (word_q[sum_jk[IDX_W-1:0]] == pat_q[k_q[IDX_W-1:0]]);
	assign last_k      = (k_q == (pl_q - LEN_W'(1)));
	assign word_eq     = (wl_q == pl_q) && ((pl_q == '0) || (occ_q != '0));

	assign status.accept      = accept;
	assign status.close_req   = (chars.char_code == CHAR_SPACE) || chars.line_end;
	assign status.in_end      = chars.line_end;
	assign status.word_full   = (wi_q >= NUM_W'(MAX_WORDS));
	assign status.search_done = (pl_q == '0) || (span_end > {1'b0, wl_q});
	assign status.out_free    = !out_valid_q || reports.ready;

	// The first word of a line is written into the pattern store as it arrives.
	always_ff @(posedge clk) begin
		if (store_letter) begin
			word_q[wl_q[IDX_W-1:0]] <= chars.char_code;
			if (wi_q == '0) begin
				pat_q[wl_q[IDX_W-1:0]] <= chars.char_code;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q  <= '0;
			pl_q  <= '0;
			wi_q  <= '0;
			eqc_q <= '0;
			j_q   <= '0;
			k_q   <= '0;
			occ_q <= '0;
		end else begin
			if (store_letter) begin
				wl_q <= wl_q + LEN_W'(1);
			end
			if (cmd.prep) begin
				if (status.word_full) begin
					wl_q <= '0;
				end else begin
					if (wi_q == '0) begin
						pl_q <= wl_q;
					end
					j_q   <= '0;
					k_q   <= '0;
					occ_q <= '0;
				end
			end
			if (cmd.step) begin
				if (chars_match && !last_k) begin
					k_q <= k_q + LEN_W'(1);
				end else begin
					if (chars_match) begin
						occ_q <= occ_q + OCC_W'(1);
					end
					j_q <= j_q + LEN_W'(1);
					k_q <= '0;
				end
			end
			if (cmd.emit_word) begin
				wi_q <= wi_q + NUM_W'(1);
				wl_q <= '0;
				if (word_eq) begin
					eqc_q <= eqc_q + NUM_W'(1);
				end
			end
			if (cmd.emit_total) begin
				wi_q  <= '0;
				eqc_q <= '0;
				pl_q  <= '0;
				wl_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_word || cmd.emit_total) begin
			out_valid_q <= 1'b1;
		end else if (reports.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_word) begin
			out_total_q <= 1'b0;
			out_num_q   <= wi_q + NUM_W'(1);
			out_eq_q    <= word_eq;
			out_occ_q   <= occ_q;
			out_etot_q  <= '0;
			out_last_q  <= cmd.run_last;
		end else if (cmd.emit_total) begin
			out_total_q <= 1'b1;
			out_num_q   <= '0;
			out_eq_q    <= 1'b0;
			out_occ_q   <= '0;
			out_etot_q  <= eqc_q;
			out_last_q  <= 1'b1;
		end
	end

	assign reports.valid       = out_valid_q;
	assign reports.is_total    = out_total_q;
	assign reports.word_number = out_num_q;
	assign reports.word_equal  = out_eq_q;
	assign reports.occurrences = out_occ_q;
	assign reports.equal_total = out_etot_q;
	assign reports.run_last    = out_last_q;

endmodule

[rtl/core/first_word_match_counter_top.sv]
// Channel   Direction  Transfer carries
// chars     in         char_code (8 bits), line_end (1 bit)
// reports   out        is_total, word_number, word_equal, occurrences, equal_total, run_last
//
// A letter or a character that does not close a word is only accepted. A space or line end
// is accepted, then the word is prepared, searched one letter compare at a time and
// reported; a word past the limit goes only through the accept and prepare steps. A line
// end adds the total report. The output register means a stalled sink holds the block
// only when a new report is due.
// Reset is asynchronous and active low; the letter stores need no clearing.
module first_word_match_counter_top import fwmc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	fwmc_char_if.sink  chars,
	fwmc_rpt_if.source reports
);

	// The controller sequences accept, search and report; the datapath holds the
	// stores, the search counters and the output register.
	fwmc_cmd_t    cmd;
	fwmc_status_t status;

	fwmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	fwmc_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars),
		.reports (reports),
		.cmd     (cmd),
		.status  (status)
	);

endmodule

[rtl/core/fwmc_checker.sv]
module fwmc_checker import fwmc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              c_valid,
	input logic              c_ready,
	input logic [CHAR_W-1:0] c_code,
	input logic              c_end,
	input logic              r_valid,
	input logic              r_ready,
	input logic              r_total,
	input logic [NUM_W-1:0]  r_num,
	input logic              r_eq,
	input logic [OCC_W-1:0]  r_occ,
	input logic [NUM_W-1:0]  r_etot,
	input logic              r_last
);

	// A report waiting for the sink is held.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_num) && $stable(r_total))
		else $error("report changed while stalled");

	a_total_shape: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_total |-> r_last && (r_num == '0) && !r_eq && (r_occ == '0))
		else $error("malformed total report");

	a_word_shape: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_total |-> (r_num != '0) && (r_etot == '0))
		else $error("malformed word report");

	// A word-closing character keeps the block busy in the next cycle.
	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		c_valid && c_ready && (c_end || (c_code == CHAR_SPACE)) |=> !c_ready)
		else $error("input taken while closing a word");

endmodule

bind first_word_match_counter_top fwmc_checker u_fwmc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.c_valid (chars.valid),
	.c_ready (chars.ready),
	.c_code  (chars.char_code),
	.c_end   (chars.line_end),
	.r_valid (reports.valid),
	.r_ready (reports.ready),
	.r_total (reports.is_total),
	.r_num   (reports.word_number),
	.r_eq    (reports.word_equal),
	.r_occ   (reports.occurrences),
	.r_etot  (reports.equal_total),
	.r_last  (reports.run_last)
);

[sim/first_word_match_counter_top_tb.sv]
module first_word_match_counter_top_tb import fwmc_pkg::*; ;

	timeunit 1ns;
	timeprecision 1ps;

	// One character transfer as the sender offers it.
	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} char_item_t;

	// One report transfer, laid out field by field as the block delivers it.
	typedef struct packed {
		logic             is_total;
		logic [NUM_W-1:0] word_number;
		logic             word_equal;
		logic [OCC_W-1:0] occurrences;
		logic [NUM_W-1:0] equal_total;
		logic             run_last;
	} report_t;

	localparam int RANDOM_ITEMS = 1900;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 200;

	logic clk;
	logic arst_n;

	fwmc_char_if chars_bus ();
	fwmc_rpt_if  report_bus ();

	first_word_match_counter_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_bus),
		.reports (report_bus)
	);

	// Characters waiting to be offered, and reports that the block still owes us.
	char_item_t pending_chars[$];
	report_t    expected_reports[$];

	// Handshake bookkeeping between the driver and the monitor.
	int chars_given = 0;
	int chars_taken = 0;
	int total_chars = 0;
	int phase_len   = 1 << 30;

	// Long receiver hold-off, counted in its own process.
	int hold_start = 1 << 30;
	int hold_left  = 0;
	bit hold_done  = 1'b0;

	// Our own copy of the line state: the pattern, the word being built and the counters.
	logic [CHAR_W-1:0] pattern_store [MAX_LETTERS];
	logic [CHAR_W-1:0] word_store    [MAX_LETTERS];
	int pattern_len = 0;
	int word_len    = 0;
	int word_count  = 0;
	int equal_count = 0;

	// Figures for the closing summary.
	int error_count     = 0;
	int reports_seen    = 0;
	int lines_closed    = 0;
	int words_reported  = 0;
	int hits_reported   = 0;
	int letters_clipped = 0;
	int words_skipped   = 0;

	// The clock runs from time zero with a 12 ns period.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Every input of the block has a known value from the very start, and reset starts low.
	// It is released at a falling edge with a nonblocking assignment, so that the driver
	// processes at that edge still see the old value.
	initial begin
		arst_n           = 1'b0;
		chars_bus.valid     = 1'b0;
		chars_bus.char_code = '0;
		chars_bus.line_end  = 1'b0;
		report_bus.ready    = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Fixed limit on the whole run, far beyond what a correct block needs.
	initial begin
		#15_000_000;
		$display("timeout: %0d of %0d characters taken, %0d reports outstanding",
			chars_taken, total_chars, expected_reports.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Prints one line per discrepancy and keeps count of them.
	task automatic note_error(input string msg);
		$display("error at %0t ns: %s", $realtime, msg);
		error_count++;
	endtask

	// Field-by-field comparison of a delivered report with the oldest prediction.
	task automatic check_report(input report_t got, input report_t want);
		string tag;
		tag = $sformatf("report %0d", reports_seen);
		if (got.is_total !== want.is_total)
			note_error($sformatf("%s: is_total %0d, predicted %0d", tag,
				got.is_total, want.is_total));
		if (got.word_number !== want.word_number)
			note_error($sformatf("%s: word_number %0d, predicted %0d", tag,
				got.word_number, want.word_number));
		if (got.word_equal !== want.word_equal)
			note_error($sformatf("%s: word_equal %0d, predicted %0d", tag,
				got.word_equal, want.word_equal));
		if (got.occurrences !== want.occurrences)
			note_error($sformatf("%s: occurrences %0d, predicted %0d", tag,
				got.occurrences, want.occurrences));
		if (got.equal_total !== want.equal_total)
			note_error($sformatf("%s: equal_total %0d, predicted %0d", tag,
				got.equal_total, want.equal_total));
		if (got.run_last !== want.run_last)
			note_error($sformatf("%s: run_last %0d, predicted %0d", tag,
				got.run_last, want.run_last));
	endtask

	// Works out the reports that one accepted character causes and queues them in order.
	// A letter grows the word (silently clipped at MAX_LETTERS), a space or the line end
	// closes it, and the line end adds the total report and clears the line state. The
	// stores keep their contents across lines, but only entries below the current lengths
	// are ever compared.
	task automatic predict_char(input logic [CHAR_W-1:0] code, input logic ends);
		report_t batch[$];
		report_t rpt;
		bit      is_letter;
		bit      same;
		bit      hit;
		int      hits;
		is_letter = (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) ||
			(code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z);
		if (is_letter) begin
			if (word_len < MAX_LETTERS) begin
				word_store[word_len] = code;
				word_len++;
			end else begin
				letters_clipped++;
			end
		end
		if (code == CHAR_SPACE || ends) begin
			if (word_count >= MAX_WORDS) begin
				// Past the word limit the word is dropped without a report.
				words_skipped++;
			end else begin
				if (word_count == 0) begin
					for (int i = 0; i < word_len; i++)
						pattern_store[i] = word_store[i];
					pattern_len = word_len;
				end
				same = (word_len == pattern_len);
				if (same) begin
					for (int i = 0; i < word_len; i++)
						if (word_store[i] != pattern_store[i])
							same = 1'b0;
				end
				// Only start positions whose whole copy fits inside the word are tried,
				// and an empty pattern never matches.
				hits = 0;
				if (pattern_len != 0) begin
					for (int j = 0; j + pattern_len <= word_len; j++) begin
						hit = 1'b1;
						for (int k = 0; k < pattern_len; k++)
							if (word_store[j + k] != pattern_store[k])
								hit = 1'b0;
						if (hit)
							hits++;
					end
				end
				if (same)
					equal_count++;
				word_count++;
				rpt             = '0;
				rpt.word_number = NUM_W'(word_count);
				rpt.word_equal  = same;
				rpt.occurrences = OCC_W'(hits);
				batch.push_back(rpt);
				words_reported++;
				hits_reported += hits;
			end
			word_len = 0;
		end
		if (ends) begin
			rpt             = '0;
			rpt.is_total    = 1'b1;
			rpt.equal_total = NUM_W'(equal_count);
			batch.push_back(rpt);
			lines_closed++;
			word_count  = 0;
			equal_count = 0;
			pattern_len = 0;
			word_len    = 0;
		end
		foreach (batch[i]) begin
			if (i == batch.size() - 1)
				batch[i].run_last = 1'b1;
			expected_reports.push_back(batch[i]);
		end
	endtask

	// Idle percentage for each side: the sender idles lightly while the receiver stalls
	// heavily, then the roles swap, and the last third runs flat out on both sides.
	function automatic int idle_pct(input bit receiver);
		int ph;
		ph = (chars_taken < phase_len) ? 0 : (chars_taken < 2 * phase_len) ? 1 : 2;
		case (ph)
			0: return receiver ? 86 : 11;
			1: return receiver ? 11 : 86;
			default: return 0;
		endcase
	endfunction

	task automatic push_char(input logic [CHAR_W-1:0] code, input logic last);
		char_item_t item;
		item.code = code;
		item.last = last;
		pending_chars.push_back(item);
	endtask

	// Mostly letters from a four-letter alphabet, so that words often equal the pattern or
	// contain it, with the odd letter drawn from the whole of A-Z and a-z.
	function automatic logic [CHAR_W-1:0] pick_letter();
		case ($urandom_range(0, 9))
			0, 1: return CHAR_LOWER_A;
			2, 3: return CHAR_LOWER_A + 8'd1;
			4, 5: return CHAR_UPPER_A;
			6, 7: return CHAR_UPPER_A + 8'd1;
			8: return CHAR_UPPER_A + 8'($urandom_range(0, 25));
			default: return CHAR_LOWER_A + 8'($urandom_range(0, 25));
		endcase
	endfunction

	// Builds one well-formed line with random content: a pattern word, then words that are
	// copies of it, hold one or more copies, add a letter to a copy, or are random. A few lines
	// run past the word limit, a few words past the letter limit, and stray bytes and doubled
	// spaces break the structure now and then. The line ends on its last letter, on a
	// space, or on an arbitrary byte.
	task automatic add_line();
		logic [CHAR_W-1:0] pat[$];
		logic [CHAR_W-1:0] line[$];
		bit                crowded;
		int                n_words;
		int                pat_size;
		int                n;
		int                mode;
		crowded  = ($urandom_range(0, 99) < 6);
		n_words  = crowded ? $urandom_range(30, 40) : $urandom_range(1, 8);
		pat_size = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 18) : $urandom_range(0, 3);
		if (crowded && pat_size > 3)
			pat_size = 2;
		for (int i = 0; i < pat_size; i++)
			pat.push_back(pick_letter());
		for (int w = 0; w < n_words; w++) begin
			if (w > 0) begin
				line.push_back(CHAR_SPACE);
				if ($urandom_range(0, 99) < 6)
					line.push_back(CHAR_SPACE);
			end
			if (w == 0) begin
				line = {line, pat};
			end else begin
				case ($urandom_range(0, 3))
					0: line = {line, pat};
					1: begin
						n = $urandom_range(1, 3);
						for (int c = 0; c < n; c++) begin
							if ($urandom_range(0, 1))
								line.push_back(pick_letter());
							line = {line, pat};
						end
					end
					2: begin
						if (crowded)
							n = $urandom_range(0, 2);
						else if ($urandom_range(0, 19) == 0)
							n = $urandom_range(14, 20);
						else
							n = $urandom_range(0, 6);
						for (int c = 0; c < n; c++)
							line.push_back(pick_letter());
					end
					default: begin
						line = {line, pat};
						line.push_back(pick_letter());
					end
				endcase
			end
		end
		mode = $urandom_range(0, 2);
		if (line.size() == 0 && mode == 0)
			mode = 2;
		foreach (line[i]) begin
			if ($urandom_range(0, 99) < 3)
				push_char(8'($urandom_range(0, 255)), 1'b0);
			push_char(line[i], (mode == 0) && (i == line.size() - 1));
		end
		if (mode == 1)
			push_char(CHAR_SPACE, 1'b1);
		else if (mode == 2)
			push_char(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Stimulus and end of run.
	initial begin : stimulus
		int target;

		// Directed lines. A leading space gives an empty pattern; an empty word still
		// equals it but nothing ever counts as an occurrence.
		push_char(CHAR_SPACE, 1'b0);
		push_char(CHAR_LOWER_A, 1'b1);
		// A space carrying the line end closes the last word once only.
		push_char(CHAR_SPACE, 1'b0);
		push_char(CHAR_SPACE, 1'b1);
		// Pattern "AZ" interleaved with ignored bytes, including both byte extremes and
		// the codes just outside the two letter ranges.
		push_char(CHAR_UPPER_A, 1'b0);
		push_char(8'd0, 1'b0);
		push_char(CHAR_UPPER_Z, 1'b0);
		push_char(8'd255, 1'b0);
		push_char(CHAR_UPPER_A - 8'd1, 1'b0);
		push_char(CHAR_UPPER_Z + 8'd1, 1'b0);
		push_char(CHAR_LOWER_A - 8'd1, 1'b0);
		push_char(CHAR_LOWER_Z + 8'd1, 1'b0);
		push_char(CHAR_SPACE, 1'b0);
		// "AZAZ" holds two copies, and the line then ends on the last letter of a third.
		push_char(CHAR_UPPER_A, 1'b0);
		push_char(CHAR_UPPER_Z, 1'b0);
		push_char(CHAR_UPPER_A, 1'b0);
		push_char(CHAR_UPPER_Z, 1'b0);
		push_char(CHAR_SPACE, 1'b0);
		push_char(CHAR_UPPER_A, 1'b0);
		push_char(CHAR_UPPER_Z, 1'b1);
		// A line made of nothing but an ignored byte that ends it.
		push_char(8'd9, 1'b1);
		// Overlapping copies of "aa" in "aaaz", where the last start position cannot fit.
		push_char(CHAR_LOWER_A, 1'b0);
		push_char(CHAR_LOWER_A, 1'b0);
		push_char(CHAR_SPACE, 1'b0);
		push_char(CHAR_LOWER_A, 1'b0);
		push_char(CHAR_LOWER_A, 1'b0);
		push_char(CHAR_LOWER_A, 1'b0);
		push_char(CHAR_LOWER_Z, 1'b1);

		target = pending_chars.size() + RANDOM_ITEMS;
		while (pending_chars.size() < target)
			add_line();

		total_chars = pending_chars.size();
		phase_len   = total_chars / 3;
		// The long hold-off falls early in the last third, where the sender never idles.
		hold_start  = 2 * phase_len + 20;

		while (chars_taken != total_chars)
			@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		// Keep running for a drain period so that any surplus report would still be caught.
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d characters in %0d lines: %0d word reports, %0d matches",
			total_chars, lines_closed, words_reported, hits_reported);
		$display("letters clipped from long words: %0d, words past the limit: %0d, errors: %0d",
			letters_clipped, words_skipped, error_count);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Character driver. A new item goes on the bus at a falling edge only once the previous
	// offer has been taken, so valid stays high and the payload stays stable until the
	// transfer happens; in between it may idle at random.
	always @(negedge clk) begin : drive_chars
		char_item_t nxt;
		if (arst_n && chars_given == chars_taken) begin
			if (pending_chars.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
				nxt = pending_chars.pop_front();
				chars_bus.valid     <= 1'b1;
				chars_bus.char_code <= nxt.code;
				chars_bus.line_end  <= nxt.last;
				chars_given         <= chars_given + 1;
			end else begin
				chars_bus.valid <= 1'b0;
			end
		end
	end

	// The long hold-off: once it starts, the receiver refuses reports until its countdown ends
	// while the sender keeps offering, so the block's output register fills and the character
	// channel must stall.
	always @(negedge clk) begin
		if (!hold_done && chars_taken >= hold_start) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Report receiver: ready changes only at falling edges.
	always @(negedge clk) begin
		if (arst_n)
			report_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(1'b1));
	end

	// Monitor. At each rising edge an accepted character updates the prediction, and an
	// accepted report is checked against the oldest one still outstanding.
	always @(posedge clk) begin : watch
		report_t got;
		report_t want;
		if (arst_n) begin
			if (chars_bus.valid && chars_bus.ready) begin
				predict_char(chars_bus.char_code, chars_bus.line_end);
				chars_taken <= chars_taken + 1;
			end
			if (report_bus.valid && report_bus.ready) begin
				got.is_total    = report_bus.is_total;
				got.word_number = report_bus.word_number;
				got.word_equal  = report_bus.word_equal;
				got.occurrences = report_bus.occurrences;
				got.equal_total = report_bus.equal_total;
				got.run_last    = report_bus.run_last;
				if (expected_reports.size() == 0) begin
					note_error($sformatf("report %0d arrived with none outstanding", reports_seen));
				end else begin
					want = expected_reports.pop_front();
					check_report(got, want);
				end
				reports_seen++;
			end
		end
	end

endmodule
